// ===== hdl/e2h_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2h_pkg
// Types, constants and tables shared by the equatorial to horizontal
// converter and its CORDIC unit.
// ----------------------------------------------------------------------------
package e2h_pkg;

    localparam int CORDIC_ITER_DEF = 24;

    // datapath widths
    localparam int XY_W   = 35;   // CORDIC x/y working width
    localparam int Z_W    = 34;   // CORDIC angle accumulator width
    localparam int TRIG_W = 32;   // stored sine/cosine, Q30
    localparam int MUL_W  = 33;   // shared multiplier operand width

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 35'sd652032874;
    localparam logic signed [Z_W-1:0]  Z_HALF_TURN = 34'sd2147483648;
    localparam logic [24:0]            FULL_TURN   = 25'd23592960;
    // floor(2^32 / 45)
    localparam logic [26:0]            RECIP_45    = 27'd95443717;
    localparam logic [23:0]            SPD_RESET   = 24'd256;

    // configuration register indexes
    localparam logic [1:0] REG_LATITUDE = 2'd0;
    localparam logic [1:0] REG_AZ_SPD   = 2'd1;
    localparam logic [1:0] REG_ALT_SPD  = 2'd2;

    // atan(2^-i) as binary angle, 2^32 per turn
    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [24:0]        sidereal_time;
        logic [24:0]        right_ascension;
        logic signed [23:0] declination;
    } in_item_t;

    typedef struct packed {
        logic [24:0]        azimuth;
        logic signed [23:0] altitude;
        logic signed [31:0] az_step_target;
        logic signed [31:0] alt_step_target;
        logic               target_changed;
    } out_item_t;

    typedef struct packed {
        logic                   start;
        logic                   vector_mode;
        logic [31:0]            angle;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
    } cordic_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] sin;
        logic signed [TRIG_W-1:0] cos;
        logic signed [Z_W-1:0]    angle;
    } cordic_rsp_t;

endpackage

// ===== hdl/e2h_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2h_cordic
// One-iteration-per-cycle CORDIC: rotation mode gives sin/cos of a binary
// angle, vectoring mode gives atan2(y, x) as a binary angle.
// ----------------------------------------------------------------------------
module e2h_cordic
    import e2h_pkg::*;
#(
    parameter int ITERATIONS = CORDIC_ITER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cordic_req_t req,
    output cordic_rsp_t rsp
);

    logic                   busy_reg;
    logic                   done_reg;
    logic                   neg_reg;
    logic                   zero_reg;
    logic                   vec_reg;
    logic [5:0]             cnt_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  step_ang;
    logic                   dir;
    logic                   fold;
    logic [31:0]            a_fold;

    always_comb begin
        xs       = x_reg >>> cnt_reg[4:0];
        ys       = y_reg >>> cnt_reg[4:0];
        step_ang = signed'({2'b00, ATAN_TABLE[cnt_reg[4:0]]});
        dir      = vec_reg ? y_reg[XY_W-1] : ~z_reg[Z_W-1];
        // quadrants 2 and 3: turn by half a turn, negate results at the end
        fold     = req.angle[31] ^ req.angle[30];
        a_fold   = {req.angle[31] ^ fold, req.angle[30:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !req.start && busy_reg && (cnt_reg == 6'(ITERATIONS - 1));
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 6'(ITERATIONS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg <= '0;
            vec_reg <= req.vector_mode;
            if (req.vector_mode) begin
                neg_reg  <= 1'b0;
                zero_reg <= (req.x == '0) && (req.y == '0);
                if (req.x[XY_W-1]) begin
                    x_reg <= -req.x;
                    y_reg <= -req.y;
                    z_reg <= Z_HALF_TURN;
                end else begin
                    x_reg <= req.x;
                    y_reg <= req.y;
                    z_reg <= '0;
                end
            end else begin
                neg_reg  <= fold;
                zero_reg <= 1'b0;
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= Z_W'(signed'(a_fold));
            end
        end else if (busy_reg) begin
            if (dir) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step_ang;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step_ang;
            end
            cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_comb begin
        rsp.done  = done_reg;
        rsp.sin   = TRIG_W'(neg_reg ? -y_reg : y_reg);
        rsp.cos   = TRIG_W'(neg_reg ? -x_reg : x_reg);
        rsp.angle = zero_reg ? '0 : z_reg;
    end

endmodule

// ===== hdl/equatorial_to_horizontal_steps.sv =====
`timescale 1ns / 1ps
// An item is taken only in the idle state. Its result is loaded after five
//   passes through the one CORDIC unit plus an integer square root and the
//   shared multiplier steps, and only then is the next item taken. A
//   finished result waits in the output register while the next item is
//   taken; a new result waits until the previous one has been read.
// Reset: synchronous active-low aresetn; clears control, step history, config.
// ----------------------------------------------------------------------------
// equatorial_to_horizontal_steps
// Converts sidereal time, right ascension and declination into azimuth,
// altitude and motor step targets, using one CORDIC unit and one multiplier.
// ----------------------------------------------------------------------------
module equatorial_to_horizontal_steps
    import e2h_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    // sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;   // wait for an item
    localparam logic [4:0] ST_BMUL  = 5'd1;   // degrees -> binary angle, multiply
    localparam logic [4:0] ST_BFIX  = 5'd2;   // quotient correction, start CORDIC
    localparam logic [4:0] ST_ROT   = 5'd3;   // wait for sin/cos
    localparam logic [4:0] ST_M1    = 5'd4;
    localparam logic [4:0] ST_M2    = 5'd5;
    localparam logic [4:0] ST_M3    = 5'd6;
    localparam logic [4:0] ST_M4    = 5'd7;
    localparam logic [4:0] ST_M5    = 5'd8;
    localparam logic [4:0] ST_M6    = 5'd9;
    localparam logic [4:0] ST_M7    = 5'd10;
    localparam logic [4:0] ST_SQRT  = 5'd11;  // cos(alt) by integer square root
    localparam logic [4:0] ST_ALT   = 5'd12;  // start atan2 for altitude
    localparam logic [4:0] ST_ALTW  = 5'd13;
    localparam logic [4:0] ST_ALTM  = 5'd14;
    localparam logic [4:0] ST_ALTD  = 5'd15;
    localparam logic [4:0] ST_AZ    = 5'd16;  // start atan2 for azimuth
    localparam logic [4:0] ST_AZW   = 5'd17;
    localparam logic [4:0] ST_AZM   = 5'd18;
    localparam logic [4:0] ST_AZD   = 5'd19;
    localparam logic [4:0] ST_STEPA = 5'd20;
    localparam logic [4:0] ST_STEPB = 5'd21;
    localparam logic [4:0] ST_FIN   = 5'd22;  // load output register

    localparam logic signed [35:0] ONE_Q30    = 36'sd1073741824;
    localparam logic [60:0]        ONE_Q60    = 61'h1000_0000_0000_0000;
    localparam logic signed [MUL_W-1:0] DEG_360 = 33'sd360;

    logic [4:0] state_reg;

    // configuration
    logic signed [23:0] lat_reg;
    logic [23:0]        az_spd_reg;
    logic [23:0]        alt_spd_reg;

    // per-item working registers
    logic [24:0]              ha_reg;
    logic signed [23:0]       dec_reg;
    logic [1:0]               k_reg;       // which angle goes through sin/cos
    logic [24:0]              mag_reg;
    logic                     sgn_reg;
    logic signed [TRIG_W-1:0] sh_reg, ch_reg, sd_reg, cd_reg, sl_reg, cl_reg;
    logic signed [TRIG_W-1:0] cdcl_reg;
    logic signed [35:0]       acc_reg;
    logic signed [TRIG_W-1:0] salt_reg;
    logic signed [TRIG_W-1:0] azy_reg;
    logic signed [32:0]       azx_reg;
    logic [61:0]              sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [4:0]               sq_cnt_reg;
    logic signed [32:0]       alt_b_reg;
    logic [31:0]              az_b_reg;
    logic signed [23:0]       alt_deg_reg;
    logic [24:0]              az_deg_reg;
    logic signed [31:0]       az_steps_reg;

    // history and output
    logic signed [31:0] last_az_reg;
    logic signed [31:0] last_alt_reg;
    logic               m_valid_reg;
    out_item_t          out_reg;

    // shared multiplier
    logic signed [MUL_W-1:0]   ma, mb;
    logic signed [2*MUL_W-1:0] prod_reg;
    logic signed [35:0]        q30;

    cordic_req_t creq;
    cordic_rsp_t crsp;

    logic               s_fire;
    logic signed [26:0] hd, hd_p1, hd_p2, hd_m1;
    logic [24:0]        ha_c;
    logic signed [25:0] ang_sel;
    logic [24:0]        mag_c;
    logic [20:0]        q1_0;
    logic [26:0]        rem_c;
    logic [20:0]        q1_c;
    logic [33:0]        q_c;
    logic [31:0]        bang_c;
    logic signed [35:0] salt_sum;
    logic signed [TRIG_W-1:0] salt_c;
    logic [61:0]        sq_t;
    logic signed [2*MUL_W-1:0] rnd;
    logic [25:0]        az_t;
    logic signed [31:0] alt_steps_c;

    // truncate toward zero of a Q24 step product, saturated to 32 bits
    function automatic logic signed [31:0] steps_of(input logic signed [2*MUL_W-1:0] p);
        logic [2*MUL_W-1:0] mag;
        logic [41:0]        r;
        mag = p[2*MUL_W-1] ? (2*MUL_W)'(-p) : (2*MUL_W)'(p);
        r   = mag[2*MUL_W-1:24];
        if (p[2*MUL_W-1]) begin
            steps_of = (r > 42'h0_8000_0000) ? 32'sh8000_0000 : 32'(-r);
        end else begin
            steps_of = (r > 42'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(r);
        end
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign q30       = prod_reg[65:30];

    // hour angle, wrapped into one turn (difference lies within +-2 turns)
    always_comb begin
        hd    = 27'(signed'({2'b00, s_data.sidereal_time}))
              - 27'(signed'({2'b00, s_data.right_ascension}));
        hd_p1 = hd + 27'(signed'({2'b00, FULL_TURN}));
        hd_p2 = hd_p1 + 27'(signed'({2'b00, FULL_TURN}));
        hd_m1 = hd - 27'(signed'({2'b00, FULL_TURN}));
        if (hd[26]) begin
            ha_c = hd_p1[26] ? hd_p2[24:0] : hd_p1[24:0];
        end else if (hd >= 27'(signed'({2'b00, FULL_TURN}))) begin
            ha_c = hd_m1[24:0];
        end else begin
            ha_c = hd[24:0];
        end
    end

    // degrees -> binary angle: deg * 8192 / 45 = 182*deg + floor(2*deg / 45)
    always_comb begin
        case (k_reg)
            2'd0:    ang_sel = signed'({1'b0, ha_reg});
            2'd1:    ang_sel = 26'(dec_reg);
            default: ang_sel = 26'(lat_reg);
        endcase
        mag_c  = ang_sel[25] ? 25'(-ang_sel) : ang_sel[24:0];
        q1_0   = prod_reg[52:32];
        rem_c  = 27'({mag_reg, 1'b0}) - 27'(q1_0) * 27'd45;
        q1_c   = q1_0 + 21'(rem_c >= 27'd45);
        q_c    = 34'(mag_reg) * 34'd182 + 34'(q1_c);
        bang_c = sgn_reg ? (~q_c[31:0]) + 32'd1 : q_c[31:0];
    end

    // sin(alt), clamped to +-1
    always_comb begin
        salt_sum = acc_reg + q30;
        if (salt_sum > ONE_Q30) begin
            salt_c = TRIG_W'(ONE_Q30);
        end else if (salt_sum < -ONE_Q30) begin
            salt_c = TRIG_W'(-ONE_Q30);
        end else begin
            salt_c = TRIG_W'(salt_sum);
        end
    end

    // binary angle * 360 rounded back to Q16 degrees; steps from Q24 product
    always_comb begin
        sq_t        = sq_r_reg + sq_bit_reg;
        rnd         = prod_reg + 66'sd32768;
        az_t        = rnd[41:16];
        alt_steps_c = steps_of(prod_reg);
    end

    // shared multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        case (state_reg)
            ST_BMUL: begin
                ma = signed'({7'b0, mag_c, 1'b0});
                mb = signed'({6'b0, RECIP_45});
            end
            ST_M1: begin
                ma = MUL_W'(cd_reg);
                mb = MUL_W'(cl_reg);
            end
            ST_M2: begin
                ma = MUL_W'(sd_reg);
                mb = MUL_W'(sl_reg);
            end
            ST_M3: begin
                ma = MUL_W'(cdcl_reg);
                mb = MUL_W'(ch_reg);
            end
            ST_M4: begin
                ma = MUL_W'(cdcl_reg);
                mb = MUL_W'(sh_reg);
            end
            ST_M5: begin
                ma = MUL_W'(salt_reg);
                mb = MUL_W'(salt_reg);
            end
            ST_M6: begin
                ma = MUL_W'(sl_reg);
                mb = MUL_W'(salt_reg);
            end
            ST_ALTM: begin
                ma = alt_b_reg;
                mb = DEG_360;
            end
            ST_AZM: begin
                ma = signed'({1'b0, az_b_reg});
                mb = DEG_360;
            end
            ST_STEPA: begin
                ma = signed'({8'b0, az_deg_reg});
                mb = signed'({9'b0, az_spd_reg});
            end
            // altitude step product is held while the result waits
            ST_STEPB, ST_FIN: begin
                ma = MUL_W'(alt_deg_reg);
                mb = signed'({9'b0, alt_spd_reg});
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ma * mb;
    end

    // CORDIC requests: rotation for the three angles, vectoring for alt and az
    always_comb begin
        creq.start       = (state_reg == ST_BFIX) || (state_reg == ST_ALT)
                        || (state_reg == ST_AZ);
        creq.vector_mode = (state_reg != ST_BFIX);
        creq.angle       = bang_c;
        if (state_reg == ST_ALT) begin
            creq.x = XY_W'(signed'({1'b0, sq_r_reg[30:0]}));
            creq.y = XY_W'(salt_reg);
        end else begin
            creq.x = XY_W'(azx_reg);
            creq.y = XY_W'(azy_reg);
        end
    end

    e2h_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (creq),
        .rsp     (crsp)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg     <= '0;
            az_spd_reg  <= SPD_RESET;
            alt_spd_reg <= SPD_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LATITUDE: lat_reg     <= signed'(cfg_data);
                REG_AZ_SPD:   az_spd_reg  <= cfg_data;
                REG_ALT_SPD:  alt_spd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            last_az_reg  <= '0;
            last_alt_reg <= '0;
            k_reg        <= '0;
        end else begin
            // in ST_FIN a read result is replaced by the new one below
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        k_reg     <= '0;
                        state_reg <= ST_BMUL;
                    end
                end
                ST_BMUL:  state_reg <= ST_BFIX;
                ST_BFIX:  state_reg <= ST_ROT;
                ST_ROT: begin
                    if (crsp.done) begin
                        if (k_reg == 2'd2) begin
                            state_reg <= ST_M1;
                        end else begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= ST_BMUL;
                        end
                    end
                end
                ST_M1:    state_reg <= ST_M2;
                ST_M2:    state_reg <= ST_M3;
                ST_M3:    state_reg <= ST_M4;
                ST_M4:    state_reg <= ST_M5;
                ST_M5:    state_reg <= ST_M6;
                ST_M6:    state_reg <= ST_M7;
                ST_M7:    state_reg <= ST_SQRT;
                ST_SQRT: begin
                    if (sq_cnt_reg == 5'd30) begin
                        state_reg <= ST_ALT;
                    end
                end
                ST_ALT:   state_reg <= ST_ALTW;
                ST_ALTW: begin
                    if (crsp.done) begin
                        state_reg <= ST_ALTM;
                    end
                end
                ST_ALTM:  state_reg <= ST_ALTD;
                ST_ALTD:  state_reg <= ST_AZ;
                ST_AZ:    state_reg <= ST_AZW;
                ST_AZW: begin
                    if (crsp.done) begin
                        state_reg <= ST_AZM;
                    end
                end
                ST_AZM:   state_reg <= ST_AZD;
                ST_AZD:   state_reg <= ST_STEPA;
                ST_STEPA: state_reg <= ST_STEPB;
                ST_STEPB: state_reg <= ST_FIN;
                ST_FIN: begin
                    // hold here while the previous result is still unread
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        last_az_reg  <= az_steps_reg;
                        last_alt_reg <= alt_steps_c;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    ha_reg  <= ha_c;
                    dec_reg <= s_data.declination;
                end
            end
            ST_BMUL: begin
                mag_reg <= mag_c;
                sgn_reg <= ang_sel[25];
            end
            ST_ROT: begin
                if (crsp.done) begin
                    case (k_reg)
                        2'd0: begin
                            sh_reg <= crsp.sin;
                            ch_reg <= crsp.cos;
                        end
                        2'd1: begin
                            sd_reg <= crsp.sin;
                            cd_reg <= crsp.cos;
                        end
                        default: begin
                            sl_reg <= crsp.sin;
                            cl_reg <= crsp.cos;
                        end
                    endcase
                end
            end
            ST_M2:  cdcl_reg <= TRIG_W'(q30);
            ST_M3:  acc_reg  <= q30;
            ST_M4:  salt_reg <= salt_c;
            ST_M5:  azy_reg  <= TRIG_W'(-q30);
            ST_M6: begin
                sq_v_reg   <= 62'(ONE_Q60 - prod_reg[60:0]);
                sq_r_reg   <= '0;
                sq_bit_reg <= 62'(ONE_Q60);
                sq_cnt_reg <= '0;
            end
            ST_M7:  azx_reg <= 33'(36'(sd_reg) - q30);
            ST_SQRT: begin
                if (sq_v_reg >= sq_t) begin
                    sq_v_reg <= sq_v_reg - sq_t;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
            end
            ST_ALTW: begin
                if (crsp.done) begin
                    alt_b_reg <= crsp.angle[32:0];
                end
            end
            ST_ALTD: alt_deg_reg <= rnd[39:16];
            ST_AZW: begin
                if (crsp.done) begin
                    az_b_reg <= crsp.angle[31:0];
                end
            end
            // rounding up to a full turn reads as zero
            ST_AZD:   az_deg_reg   <= (az_t >= 26'(FULL_TURN)) ? '0 : az_t[24:0];
            ST_STEPB: az_steps_reg <= steps_of(prod_reg);
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_reg.azimuth         <= az_deg_reg;
                    out_reg.altitude        <= alt_deg_reg;
                    out_reg.az_step_target  <= az_steps_reg;
                    out_reg.alt_step_target <= alt_steps_c;
                    out_reg.target_changed  <= (az_steps_reg != last_az_reg)
                                            || (alt_steps_c != last_alt_reg);
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== verif/equatorial_to_horizontal_steps_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equatorial_to_horizontal_steps_test
// Self-checking bench for the equatorial to horizontal converter. A bit-exact
// fixed-point CORDIC predictor runs beside the block. Directed pointing cases
// come first, then latitude and steps-per-degree sweeps, random sky positions
// and a long output stall. Both handshakes idle at random outside burst mode.
// ----------------------------------------------------------------------------
module equatorial_to_horizontal_steps_test;
    import e2h_pkg::*;

    localparam int  ITERS     = 24;
    localparam longint TURN_Q16 = 23592960;
    localparam longint GAIN_Q30 = 652032874;
    localparam longint ONE_Q30  = 1073741824;
    localparam int  DEC_MAX   = 5898240;
    localparam int  DEG_MAX   = 23592959;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    equatorial_to_horizontal_steps #(.CORDIC_ITERATIONS(ITERS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of configuration and step history
    longint    obs_lat;
    longint    az_spd;
    longint    alt_spd;
    longint    prev_az_steps;
    longint    prev_alt_steps;

    out_item_t pointing_q[$];    // expected results, oldest first
    int        errors;
    int        items_sent;
    int        results_seen;
    int        reg_writes;
    bit        no_idle;          // burst mode: neither side idles
    int        out_hold;         // receiver stall request, in cycles

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] deg_to_turn(longint deg_q16);
        longint b;
        b = (deg_q16 * 65536) / 360;   // truncates toward zero
        return b[31:0];
    endfunction

    task automatic cordic_sin_cos(input logic [31:0] a, output longint s,
                                  output longint c);
        bit     flip;
        longint x, y, z, xn, t;
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        x = GAIN_Q30;
        y = 0;
        if (flip) a = a - 32'h80000000;
        z = $signed(a);
        for (int i = 0; i < ITERS; i++) begin
            t = ATAN_TABLE[i];
            if (z >= 0) begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - t;
            end else begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + t;
            end
            x = xn;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic longint cordic_atan2(longint y, longint x);
        longint z, xn, t;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'sd2147483648;
        end
        for (int i = 0; i < ITERS; i++) begin
            t = ATAN_TABLE[i];
            if (y < 0) begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - t;
            end else begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + t;
            end
            x = xn;
        end
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint deg_to_steps(longint deg_q16, longint spd_q8);
        longint p, r;
        p = deg_q16 * spd_q8;
        r = (p >= 0) ? (p >>> 24) : -((-p) >>> 24);
        if (r > 64'sd2147483647)  r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    task automatic predict_pointing(input in_item_t it, output out_item_t o);
        longint st, ra, dec, ha, sh, ch, sd, cd, sl, cl, cdcl, sin_alt;
        longint cmp, alt_b, alt_deg, ax, ay, az_steps, alt_steps;
        longint unsigned az_deg;
        logic [31:0] az_b;
        st  = it.sidereal_time;
        ra  = it.right_ascension;
        dec = $signed(it.declination);
        ha  = ((st - ra) % TURN_Q16 + TURN_Q16) % TURN_Q16;
        cordic_sin_cos(deg_to_turn(ha), sh, ch);
        cordic_sin_cos(deg_to_turn(dec), sd, cd);
        cordic_sin_cos(deg_to_turn(obs_lat), sl, cl);
        cdcl    = (cd * cl) >>> 30;
        sin_alt = ((sd * sl) >>> 30) + ((cdcl * ch) >>> 30);
        if (sin_alt > ONE_Q30)  sin_alt = ONE_Q30;
        if (sin_alt < -ONE_Q30) sin_alt = -ONE_Q30;
        cmp     = floor_sqrt((ONE_Q30 * ONE_Q30) - (sin_alt * sin_alt));
        alt_b   = cordic_atan2(sin_alt, cmp);
        alt_deg = (alt_b * 360 + 32768) >>> 16;
        ay      = -((cdcl * sh) >>> 30);
        ax      = sd - ((sl * sin_alt) >>> 30);
        az_b    = cordic_atan2(ay, ax);
        az_deg  = ({32'd0, az_b} * 360 + 32768) >> 16;
        if (az_deg >= TURN_Q16) az_deg = 0;   // rounds up to a full turn
        az_steps  = deg_to_steps(az_deg, az_spd);
        alt_steps = deg_to_steps(alt_deg, alt_spd);
        o.azimuth         = az_deg[24:0];
        o.altitude        = alt_deg[23:0];
        o.az_step_target  = az_steps[31:0];
        o.alt_step_target = alt_steps[31:0];
        o.target_changed  = (az_steps != prev_az_steps) || (alt_steps != prev_alt_steps);
        prev_az_steps  = az_steps;
        prev_alt_steps = alt_steps;
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, run limit
    // ------------------------------------------------------------------
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #10ms;
        $display("timeout: %0d results still pending", pointing_q.size());
        $display("equatorial_to_horizontal_steps_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------
    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    // one item on the input channel; prediction happens at acceptance
    task automatic send_item(input logic [24:0] st, input logic [24:0] ra,
                             input logic [23:0] dec);
        int        gap;
        in_item_t  it;
        out_item_t o;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        it.sidereal_time   = st;
        it.right_ascension = ra;
        it.declination     = dec;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_pointing(it, o);
        pointing_q.push_back(o);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pointing_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // register writes only with the block idle
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LATITUDE: obs_lat = $signed(val);
            REG_AZ_SPD:   az_spd  = val;
            REG_ALT_SPD:  alt_spd = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    function automatic logic [24:0] rand_angle();
        if ($urandom_range(0, 7) == 0) return 25'($urandom());   // out of range too
        return 25'($urandom_range(0, DEG_MAX));
    endfunction

    function automatic logic [23:0] rand_dec();
        int d;
        if ($urandom_range(0, 7) == 0) return 24'($urandom());
        d = $urandom_range(0, 2 * DEC_MAX);
        return 24'(d - DEC_MAX);
    endfunction

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++) send_item(rand_angle(), rand_angle(), rand_dec());
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver idling
    // ------------------------------------------------------------------
    initial begin
        int        gap;
        out_item_t want;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (out_hold > 0) begin
                m_ready <= 1'b0;
                repeat (out_hold) @(posedge aclk);
                out_hold = 0;
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_seen++;
            if (pointing_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result az=%0d alt=%0d", $realtime,
                         m_data.azimuth, m_data.altitude);
            end else begin
                want = pointing_q.pop_front();
                if (m_data.azimuth !== want.azimuth)
                    report("azimuth", m_data.azimuth, want.azimuth);
                if (m_data.altitude !== want.altitude)
                    report("altitude", m_data.altitude, want.altitude);
                if (m_data.az_step_target !== want.az_step_target)
                    report("az_step_target", m_data.az_step_target, want.az_step_target);
                if (m_data.alt_step_target !== want.alt_step_target)
                    report("alt_step_target", m_data.alt_step_target,
                           want.alt_step_target);
                if (m_data.target_changed !== want.target_changed)
                    report("target_changed", m_data.target_changed, want.target_changed);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // meridian, horizon and pole pointing at default latitude
        send_item(0, 0, 0);
        send_item(0, 0, 0);                       // same target, no change
        send_item(DEG_MAX, DEG_MAX, DEC_MAX);
        send_item(0, DEG_MAX, -DEC_MAX);          // hour angle wraps from below
        send_item(DEG_MAX, 0, 0);
        send_item(5898240, 0, 0);                 // 90 degree hour angle
        send_item(17694720, 0, 0);                // 270 degree hour angle
        send_item(25'h1FFFFFF, 0, 24'h7FFFFF);    // out of range inputs
        send_item(0, 25'h1FFFFFF, 24'h800000);
        // observer at the pole: zenith leaves both atan2 operands near zero
        write_reg(REG_LATITUDE, DEC_MAX);
        send_item(0, 0, DEC_MAX);
        send_item(11796480, 0, 0);
        send_item(0, 0, -DEC_MAX);
        write_reg(REG_LATITUDE, -DEC_MAX);
        send_item(0, 0, -DEC_MAX);
        send_item(11796480, 3, DEC_MAX);
        send_item(1, 0, 0);
        // steps-per-degree edges, zero included
        write_reg(REG_AZ_SPD, 24'hFFFFFF);
        write_reg(REG_ALT_SPD, 24'hFFFFFF);
        send_item(DEG_MAX, 0, DEC_MAX);
        send_item(0, DEG_MAX, -DEC_MAX);
        write_reg(REG_AZ_SPD, 0);
        write_reg(REG_ALT_SPD, 0);
        send_item(5898240, 0, 1000);
        send_item(5898240, 0, 1000);
        write_reg(REG_AZ_SPD, 1);
        write_reg(REG_ALT_SPD, 1);
        send_item(17694720, 0, -1000);
    endtask

    task automatic test_config_sweep();
        logic [23:0] lat_set [5] = '{DEC_MAX, -DEC_MAX, 0, 24'h7FFFFF, 24'h800000};
        for (int p = 0; p < 5; p++) begin
            write_reg(REG_LATITUDE, lat_set[p]);
            write_reg(REG_AZ_SPD, (p == 0) ? 24'hFFFFFF : 24'($urandom()));
            write_reg(REG_ALT_SPD, (p == 1) ? 24'd1 : 24'($urandom()));
            send_random(30);
        end
    endtask

    task automatic test_random_sky();
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_LATITUDE, 24'($urandom_range(0, 2 * DEC_MAX) - DEC_MAX));
            write_reg(REG_AZ_SPD, 24'($urandom_range(1, 24'hFFFFFF)));
            write_reg(REG_ALT_SPD, 24'($urandom_range(1, 4096)));
            no_idle = (p % 3 == 2);
            send_random(140);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        drain();
        out_hold = 800;   // receiver holds off while items keep coming
        no_idle  = 1'b1;
        send_random(12);
        no_idle  = 1'b0;
        send_random(12);
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_LATITUDE;
        cfg_data  <= '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        reg_writes = 0;
        no_idle = 1'b0;
        out_hold = 0;
        obs_lat = 0;
        az_spd = SPD_RESET;
        alt_spd = SPD_RESET;
        prev_az_steps = 0;
        prev_alt_steps = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_config_sweep();
        test_random_sky();
        test_output_stall();
        drain();
        repeat (200) @(posedge aclk);

        $display("covered %0d items, %0d results, %0d register writes", items_sent,
                 results_seen, reg_writes);
        $display("latitude and step-rate extremes, wrapped hour angles, long output stall");
        if (errors == 0)
            $display("equatorial_to_horizontal_steps_test: PASS");
        else
            $display("equatorial_to_horizontal_steps_test: FAIL");
        $finish;
    end

endmodule
